FILE: rtl/core/mep_pkg.sv
// ----------------------------------------------------------------------------
// Mandelbrot escape-time pixel package
// Shared constants, fixed-point types, sequencer states and the control
// structs that pass between the core and its divider and orbit datapath.
// ----------------------------------------------------------------------------
package mep_pkg;

	localparam int IMAGE_WIDTH  = 1920;
	localparam int IMAGE_HEIGHT = 1080;

	localparam int COORD_W     = 11;
	localparam int LIMIT_W     = 16;
	localparam int GRAY_W      = 8;
	localparam int FRAC_BITS   = 28;
	localparam int Q_W         = 32;
	localparam int PROD_W      = 2 * Q_W;
	localparam int SPAN_UNITS  = 3;
	localparam int GRAY_SCALE  = 255;
	localparam int LIMIT_RESET = 1000;

	localparam int DIVIDEND_W = LIMIT_W + GRAY_W;
	localparam int DIV_CNT_W  = $clog2(DIVIDEND_W);

	localparam longint SPAN_Q      = longint'(SPAN_UNITS) << FRAC_BITS;
	localparam int     RE_DIV      = IMAGE_WIDTH - 1;
	localparam int     IM_DIV      = IMAGE_HEIGHT - 1;
	localparam int     RE_L_W      = $clog2(IMAGE_WIDTH);
	localparam int     IM_L_W      = $clog2(IMAGE_HEIGHT);
	localparam int     MAP_L_W     = (RE_L_W > IM_L_W) ? RE_L_W : IM_L_W;
	localparam int     MAP_N_W     = MAP_L_W + COORD_W;
	localparam int     MAP_RECIP_W = MAP_N_W + 2;
	localparam int     MAP_PROD_W  = MAP_N_W + MAP_RECIP_W;
	localparam int     RE_SHIFT    = 2 * RE_L_W + COORD_W;
	localparam int     IM_SHIFT    = 2 * IM_L_W + COORD_W;
	localparam longint RE_QUO      = SPAN_Q / RE_DIV;
	localparam longint RE_REM      = SPAN_Q % RE_DIV;
	localparam longint IM_QUO      = SPAN_Q / IM_DIV;
	localparam longint IM_REM      = SPAN_Q % IM_DIV;
	localparam longint RE_RECIP    = ((longint'(1) << RE_SHIFT) + RE_DIV - 1) / RE_DIV;
	localparam longint IM_RECIP    = ((longint'(1) << IM_SHIFT) + IM_DIV - 1) / IM_DIV;

	typedef logic signed [Q_W-1:0] q_t;

	localparam q_t RE_MIN_Q = -(q_t'(2) <<< FRAC_BITS);
	localparam q_t IM_MIN_Q = -(q_t'(3) <<< (FRAC_BITS - 1));
	localparam logic [PROD_W-1:0] ESCAPE_Q = PROD_W'(4) << (2 * FRAC_BITS);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MAP_SCALE,
		ST_MAP_RECIP,
		ST_MAP_SUM,
		ST_ORBIT_MUL,
		ST_ORBIT_TEST,
		ST_GRAY,
		ST_RESULT
	} core_state_t;

	typedef struct packed {
		logic                  start;
		logic [DIVIDEND_W-1:0] dividend;
		logic [LIMIT_W-1:0]    divisor;
	} div_req_t;

	typedef struct packed {
		logic                  done;
		logic [DIVIDEND_W-1:0] quotient;
	} div_rsp_t;

	typedef struct packed {
		logic clear;
		logic mul;
		logic upd;
	} orbit_ctl_t;

	typedef struct packed {
		logic               escape;
		logic [LIMIT_W-1:0] count;
	} orbit_sts_t;

endpackage

FILE: rtl/core/mep_divider.sv
// ----------------------------------------------------------------------------
// Mandelbrot escape-time pixel divider
// Radix-2 restoring unsigned divider, one quotient bit per cycle, that scales
// the iteration count into a gray level.
// ----------------------------------------------------------------------------
module mep_divider (
	input  logic              clk,
	input  logic              arst_n,
	input  mep_pkg::div_req_t req,
	output mep_pkg::div_rsp_t rsp
);
	import mep_pkg::*;

	localparam logic [DIV_CNT_W-1:0] LAST_STEP = DIV_CNT_W'(DIVIDEND_W - 1);

	logic                  busy_q;
	logic                  done_q;
	logic [DIV_CNT_W-1:0]  cnt_q;
	logic [LIMIT_W-1:0]    rem_q;
	logic [LIMIT_W-1:0]    dsr_q;
	logic [DIVIDEND_W-1:0] quo_q;
	logic [LIMIT_W:0]      trial;
	logic                  qbit;
	logic [LIMIT_W-1:0]    rem_next;

	always_comb begin
		trial = {rem_q, quo_q[DIVIDEND_W-1]};
		qbit  = (trial >= {1'b0, dsr_q});
		if (qbit) begin
			rem_next = LIMIT_W'(trial - {1'b0, dsr_q});
		end else begin
			rem_next = trial[LIMIT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == LAST_STEP) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			dsr_q <= req.divisor;
			quo_q <= req.dividend;
		end else if (busy_q) begin
			rem_q <= rem_next;
			quo_q <= {quo_q[DIVIDEND_W-2:0], qbit};
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule

FILE: rtl/core/mep_orbit.sv
// ----------------------------------------------------------------------------
// Mandelbrot escape-time pixel orbit datapath
// Holds z and the iteration count, forms the three Q8.56 products of z in
// one registered stage and applies z = z*z + c with saturation in the next.
// ----------------------------------------------------------------------------
module mep_orbit (
	input  logic                clk,
	input  mep_pkg::orbit_ctl_t ctl,
	input  mep_pkg::q_t         cr,
	input  mep_pkg::q_t         ci,
	output mep_pkg::orbit_sts_t sts
);
	import mep_pkg::*;

	localparam int SUM_W = Q_W + 6;
	localparam logic signed [SUM_W-1:0] SAT_HI = {{(SUM_W-Q_W+1){1'b0}}, {(Q_W-1){1'b1}}};
	localparam logic signed [SUM_W-1:0] SAT_LO = {{(SUM_W-Q_W+1){1'b1}}, {(Q_W-1){1'b0}}};

	function automatic q_t sat_q(input logic signed [SUM_W-1:0] v);
		q_t r;
		if (v > SAT_HI) begin
			r = SAT_HI[Q_W-1:0];
		end else if (v < SAT_LO) begin
			r = SAT_LO[Q_W-1:0];
		end else begin
			r = v[Q_W-1:0];
		end
		return r;
	endfunction

	q_t                        zr_q;
	q_t                        zi_q;
	logic [LIMIT_W-1:0]        count_q;
	logic signed [PROD_W-1:0]  rr_s1;
	logic signed [PROD_W-1:0]  ii_s1;
	logic signed [PROD_W-1:0]  ri_s1;
	logic signed [PROD_W-1:0]  rr_prod;
	logic signed [PROD_W-1:0]  ii_prod;
	logic signed [PROD_W-1:0]  ri_prod;
	logic signed [PROD_W-1:0]  diff;
	logic signed [PROD_W-1:0]  re_shift;
	logic signed [PROD_W-1:0]  im_shift;
	logic signed [SUM_W-1:0]   re_sum;
	logic signed [SUM_W-1:0]   im_sum;
	logic [PROD_W-1:0]         mag;

	always_comb begin
		rr_prod  = zr_q * zr_q;
		ii_prod  = zi_q * zi_q;
		ri_prod  = zr_q * zi_q;
		diff     = rr_s1 - ii_s1;
		re_shift = diff >>> FRAC_BITS;
		im_shift = ri_s1 >>> (FRAC_BITS - 1);
		re_sum   = signed'(re_shift[SUM_W-1:0]) + SUM_W'(cr);
		im_sum   = signed'(im_shift[SUM_W-1:0]) + SUM_W'(ci);
		mag      = $unsigned(rr_s1) + $unsigned(ii_s1);
	end

	always_ff @(posedge clk) begin
		if (ctl.clear) begin
			zr_q    <= '0;
			zi_q    <= '0;
			count_q <= '0;
		end else if (ctl.upd) begin
			zr_q    <= sat_q(re_sum);
			zi_q    <= sat_q(im_sum);
			count_q <= count_q + 1'b1;
		end
		if (ctl.mul) begin
			rr_s1 <= rr_prod;
			ii_s1 <= ii_prod;
			ri_s1 <= ri_prod;
		end
	end

	assign sts.escape = (mag > ESCAPE_Q);
	assign sts.count  = count_q;

endmodule

FILE: rtl/core/mandelbrot_escape_time_pixel_core.sv
// ----------------------------------------------------------------------------
// Mandelbrot escape-time pixel core
// Maps a pixel onto the complex plane, iterates z = z*z + c in Q4.28 until
// escape or the iteration limit, and returns the count and a gray level.
// ----------------------------------------------------------------------------
// One pixel is in flight at a time and in_ready is high only while the core
// is idle. From acceptance until the core is ready again a pixel passes one
// accept state, three states that map the pixel through constant reciprocal
// multiplies, an orbit multiply and test per iteration plus a final multiply
// and test, the gray divide in the radix-2 divider, and one result state.
// With a zero limit the gray divide is skipped. The result sits in an output
// register, so the next pixel is accepted while the previous beat waits; a
// further result stalls in the result state until that beat is taken.
module mandelbrot_escape_time_pixel_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        iteration_limit_we,
	input  logic [mep_pkg::LIMIT_W-1:0] iteration_limit_wdata,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [mep_pkg::COORD_W-1:0] pixel_x,
	input  logic [mep_pkg::COORD_W-1:0] pixel_y,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [mep_pkg::LIMIT_W-1:0] iteration_count,
	output logic [mep_pkg::GRAY_W-1:0]  gray_level
);
	import mep_pkg::*;

	localparam int CMP_W = 14;

	localparam logic [Q_W-1:0]         RE_QUO_V   = Q_W'(RE_QUO);
	localparam logic [Q_W-1:0]         IM_QUO_V   = Q_W'(IM_QUO);
	localparam logic [MAP_N_W-1:0]     RE_REM_V   = MAP_N_W'(RE_REM);
	localparam logic [MAP_N_W-1:0]     IM_REM_V   = MAP_N_W'(IM_REM);
	localparam logic [MAP_RECIP_W-1:0] RE_RECIP_V = MAP_RECIP_W'(RE_RECIP);
	localparam logic [MAP_RECIP_W-1:0] IM_RECIP_V = MAP_RECIP_W'(IM_RECIP);

	core_state_t        state_q;
	core_state_t        state_d;
	logic [LIMIT_W-1:0] limit_q;
	logic [COORD_W-1:0] px_q;
	logic [COORD_W-1:0] py_q;
	logic [Q_W-1:0]     re_hi_s1;
	logic [Q_W-1:0]     im_hi_s1;
	logic [MAP_N_W-1:0] re_lo_s1;
	logic [MAP_N_W-1:0] im_lo_s1;
	logic [COORD_W-1:0] re_frac_s2;
	logic [COORD_W-1:0] im_frac_s2;
	q_t                 cr_q;
	q_t                 ci_q;
	logic [GRAY_W-1:0]  gray_q;
	logic               out_valid_q;
	logic [LIMIT_W-1:0] count_out_q;
	logic [GRAY_W-1:0]  gray_out_q;

	logic [COORD_W-1:0]    px_clamp;
	logic [COORD_W-1:0]    py_clamp;
	logic [MAP_PROD_W-1:0] re_scaled;
	logic [MAP_PROD_W-1:0] im_scaled;
	logic [MAP_PROD_W-1:0] re_frac;
	logic [MAP_PROD_W-1:0] im_frac;
	logic                  orbit_done;
	logic                  map_scale;
	logic                  map_recip;
	logic                  map_load;
	logic                  load_gray;
	logic                  clear_gray;
	logic                  out_load;
	div_req_t              div_req;
	div_rsp_t              div_rsp;
	orbit_ctl_t            orbit_ctl;
	orbit_sts_t            orbit_sts;

	mep_divider u_divider (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	mep_orbit u_orbit (
		.clk (clk),
		.ctl (orbit_ctl),
		.cr  (cr_q),
		.ci  (ci_q),
		.sts (orbit_sts)
	);

	always_comb begin
		if (CMP_W'(pixel_x) > CMP_W'(IMAGE_WIDTH - 1)) begin
			px_clamp = COORD_W'(IMAGE_WIDTH - 1);
		end else begin
			px_clamp = pixel_x;
		end
		if (CMP_W'(pixel_y) > CMP_W'(IMAGE_HEIGHT - 1)) begin
			py_clamp = COORD_W'(IMAGE_HEIGHT - 1);
		end else begin
			py_clamp = pixel_y;
		end
		re_scaled  = MAP_PROD_W'(re_lo_s1) * MAP_PROD_W'(RE_RECIP_V);
		im_scaled  = MAP_PROD_W'(im_lo_s1) * MAP_PROD_W'(IM_RECIP_V);
		re_frac    = re_scaled >> RE_SHIFT;
		im_frac    = im_scaled >> IM_SHIFT;
		orbit_done = (orbit_sts.count >= limit_q) || orbit_sts.escape;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_MAP_SCALE;
				end
			end
			ST_MAP_SCALE: begin
				state_d = ST_MAP_RECIP;
			end
			ST_MAP_RECIP: begin
				state_d = ST_MAP_SUM;
			end
			ST_MAP_SUM: begin
				state_d = ST_ORBIT_MUL;
			end
			ST_ORBIT_MUL: begin
				state_d = ST_ORBIT_TEST;
			end
			ST_ORBIT_TEST: begin
				if (!orbit_done) begin
					state_d = ST_ORBIT_MUL;
				end else if (limit_q == '0) begin
					state_d = ST_RESULT;
				end else begin
					state_d = ST_GRAY;
				end
			end
			ST_GRAY: begin
				if (div_rsp.done) begin
					state_d = ST_RESULT;
				end
			end
			ST_RESULT: begin
				if (!out_valid_q || out_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		in_ready         = 1'b0;
		div_req.start    = 1'b0;
		div_req.dividend = '0;
		div_req.divisor  = '0;
		orbit_ctl.clear  = 1'b0;
		orbit_ctl.mul    = 1'b0;
		orbit_ctl.upd    = 1'b0;
		map_scale        = 1'b0;
		map_recip        = 1'b0;
		map_load         = 1'b0;
		load_gray        = 1'b0;
		clear_gray       = 1'b0;
		out_load         = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
			end
			ST_MAP_SCALE: begin
				map_scale = 1'b1;
			end
			ST_MAP_RECIP: begin
				map_recip = 1'b1;
			end
			ST_MAP_SUM: begin
				map_load        = 1'b1;
				orbit_ctl.clear = 1'b1;
			end
			ST_ORBIT_MUL: begin
				orbit_ctl.mul = 1'b1;
			end
			ST_ORBIT_TEST: begin
				orbit_ctl.upd    = !orbit_done;
				clear_gray       = orbit_done && (limit_q == '0);
				div_req.start    = orbit_done && (limit_q != '0);
				div_req.dividend = DIVIDEND_W'(orbit_sts.count) * DIVIDEND_W'(GRAY_SCALE);
				div_req.divisor  = limit_q;
			end
			ST_GRAY: begin
				load_gray = div_rsp.done;
			end
			ST_RESULT: begin
				out_load = !out_valid_q || out_ready;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			limit_q     <= LIMIT_W'(LIMIT_RESET);
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (iteration_limit_we) begin
				limit_q <= iteration_limit_wdata;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			px_q <= px_clamp;
			py_q <= py_clamp;
		end
		if (map_scale) begin
			re_hi_s1 <= RE_QUO_V * Q_W'(px_q);
			im_hi_s1 <= IM_QUO_V * Q_W'(py_q);
			re_lo_s1 <= RE_REM_V * MAP_N_W'(px_q);
			im_lo_s1 <= IM_REM_V * MAP_N_W'(py_q);
		end
		if (map_recip) begin
			re_frac_s2 <= re_frac[COORD_W-1:0];
			im_frac_s2 <= im_frac[COORD_W-1:0];
		end
		if (map_load) begin
			cr_q <= RE_MIN_Q + q_t'(re_hi_s1 + Q_W'(re_frac_s2));
			ci_q <= IM_MIN_Q + q_t'(im_hi_s1 + Q_W'(im_frac_s2));
		end
		if (clear_gray) begin
			gray_q <= '0;
		end else if (load_gray) begin
			gray_q <= div_rsp.quotient[GRAY_W-1:0];
		end
		if (out_load) begin
			count_out_q <= orbit_sts.count;
			gray_out_q  <= gray_q;
		end
	end

	assign out_valid       = out_valid_q;
	assign iteration_count = count_out_q;
	assign gray_level      = gray_out_q;

endmodule
